FILE: rtl/core/aabbt_pkg.sv
// Shared types and constants for the box affine transform unit.
package aabbt_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int COEF_WIDTH      = 20;
  localparam int FRAC_BITS       = 16;
  localparam int NUM_COLS        = 3;
  localparam int ROW_WIDTH       = NUM_COLS * COEF_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = ROW_WIDTH;

  // corner + position, exact
  localparam int SUM_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = SUM_WIDTH + COEF_WIDTH;
  localparam int TERM_WIDTH = PROD_WIDTH - FRAC_BITS;
  // three terms plus translation
  localparam int ACC_WIDTH  = TERM_WIDTH + 2;
  localparam int DIFF_WIDTH = ACC_WIDTH + 1;

  localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = ROW_WIDTH'(1) << FRAC_BITS;
  localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = ROW_WIDTH'(1) << (FRAC_BITS + COEF_WIDTH);
  localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET =
    ROW_WIDTH'(1) << (FRAC_BITS + 2 * COEF_WIDTH);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef sum_t [NUM_COLS-1:0]           sum_vec_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
  } box_in_t;

  typedef struct packed {
    coord_t new_lo_x;
    coord_t new_lo_y;
    coord_t new_lo_z;
    coord_t new_hi_x;
    coord_t new_hi_y;
    coord_t new_hi_z;
  } box_out_t;

endpackage

FILE: rtl/core/aabb_affine_transform_unit.sv
// Top level of the axis-aligned box affine transform unit.
//
// Usage: drive a box on request and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy is high only during
// reset and for the cycle after it, so a new box may be sent every cycle.
// Each box yields one result: done is high for exactly one cycle while the
// transformed box is on result. The pipeline has five stages: input register,
// corner sums, floored products, per-axis min/max sums, saturated result
// register. Throughput is one box per cycle; the eighteen coefficient
// multipliers sit in a single stage.
// The receiver cannot hold results off and needs none.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// indices 0-2 are the x/y/z coefficient rows, 3-5 the translations, others
// are ignored. Write only while no box is in flight.
// Reset clears the pipeline valids and loads the identity transform with no
// translation.
module aabb_affine_transform_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  aabbt_pkg::box_in_t                    request,
  output logic                                  done,
  output aabbt_pkg::box_out_t                   result,
  input  logic                                  cfg_we,
  input  logic [aabbt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [aabbt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import aabbt_pkg::*;

  logic [ROW_WIDTH-1:0] row_x, row_y, row_z;
  coord_t               shift_x, shift_y, shift_z;
  logic                 busy_q;
  logic [3:0]           valid_pipe;
  box_in_t              req_q;
  sum_vec_t             lo_sum, hi_sum;
  coord_t               pos_x, pos_y, pos_z;
  coord_t               lo_res_x, lo_res_y, lo_res_z;
  coord_t               hi_res_x, hi_res_y, hi_res_z;
  logic                 accept;

  assign busy   = rst || busy_q;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x   <= ROW_X_RESET;
      row_y   <= ROW_Y_RESET;
      row_z   <= ROW_Z_RESET;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_X:   row_x   <= cfg_data[ROW_WIDTH-1:0];
        REG_ROW_Y:   row_y   <= cfg_data[ROW_WIDTH-1:0];
        REG_ROW_Z:   row_z   <= cfg_data[ROW_WIDTH-1:0];
        REG_SHIFT_X: shift_x <= cfg_data[COORD_WIDTH-1:0];
        REG_SHIFT_Y: shift_y <= cfg_data[COORD_WIDTH-1:0];
        REG_SHIFT_Z: shift_z <= cfg_data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q     <= 1'b1;
      valid_pipe <= '0;
      done       <= 1'b0;
    end else begin
      busy_q     <= 1'b0;
      valid_pipe <= {valid_pipe[2:0], accept};
      done       <= valid_pipe[3];
    end
  end

  // hold the request, then form the corners shifted by the position
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    lo_sum[0] <= SUM_WIDTH'(req_q.lo_x) + SUM_WIDTH'(req_q.pos_x);
    lo_sum[1] <= SUM_WIDTH'(req_q.lo_y) + SUM_WIDTH'(req_q.pos_y);
    lo_sum[2] <= SUM_WIDTH'(req_q.lo_z) + SUM_WIDTH'(req_q.pos_z);
    hi_sum[0] <= SUM_WIDTH'(req_q.hi_x) + SUM_WIDTH'(req_q.pos_x);
    hi_sum[1] <= SUM_WIDTH'(req_q.hi_y) + SUM_WIDTH'(req_q.pos_y);
    hi_sum[2] <= SUM_WIDTH'(req_q.hi_z) + SUM_WIDTH'(req_q.pos_z);
    pos_x     <= req_q.pos_x;
    pos_y     <= req_q.pos_y;
    pos_z     <= req_q.pos_z;
  end

  aabbt_axis u_axis_x (
    .clk    (clk),
    .row    (row_x),
    .shift  (shift_x),
    .lo_sum (lo_sum),
    .hi_sum (hi_sum),
    .pos    (pos_x),
    .lo_res (lo_res_x),
    .hi_res (hi_res_x)
  );

  aabbt_axis u_axis_y (
    .clk    (clk),
    .row    (row_y),
    .shift  (shift_y),
    .lo_sum (lo_sum),
    .hi_sum (hi_sum),
    .pos    (pos_y),
    .lo_res (lo_res_y),
    .hi_res (hi_res_y)
  );

  aabbt_axis u_axis_z (
    .clk    (clk),
    .row    (row_z),
    .shift  (shift_z),
    .lo_sum (lo_sum),
    .hi_sum (hi_sum),
    .pos    (pos_z),
    .lo_res (lo_res_z),
    .hi_res (hi_res_z)
  );

  always_ff @(posedge clk) begin
    if (valid_pipe[3]) begin
      result.new_lo_x <= lo_res_x;
      result.new_lo_y <= lo_res_y;
      result.new_lo_z <= lo_res_z;
      result.new_hi_x <= hi_res_x;
      result.new_hi_y <= hi_res_y;
      result.new_hi_z <= hi_res_z;
    end
  end

  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result strobe without a matching request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("request produced no result");

  a_result_ordered: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(result.new_lo_x) <= $signed(result.new_hi_x)) &&
             ($signed(result.new_lo_y) <= $signed(result.new_hi_y)) &&
             ($signed(result.new_lo_z) <= $signed(result.new_hi_z)))
    else $error("result minimum exceeds maximum");

endmodule

FILE: rtl/core/aabbt_axis.sv
// One output axis: products, per-column min/max, sums and saturation.
module aabbt_axis (
  input  logic                          clk,
  input  logic [aabbt_pkg::ROW_WIDTH-1:0] row,
  input  aabbt_pkg::coord_t             shift,
  input  aabbt_pkg::sum_vec_t           lo_sum,
  input  aabbt_pkg::sum_vec_t           hi_sum,
  input  aabbt_pkg::coord_t             pos,
  output aabbt_pkg::coord_t             lo_res,
  output aabbt_pkg::coord_t             hi_res
);
  import aabbt_pkg::*;

  logic signed [TERM_WIDTH-1:0] term_lo [NUM_COLS];
  logic signed [TERM_WIDTH-1:0] term_hi [NUM_COLS];
  logic signed [TERM_WIDTH-1:0] term_lo_next [NUM_COLS];
  logic signed [TERM_WIDTH-1:0] term_hi_next [NUM_COLS];
  logic signed [ACC_WIDTH-1:0]  acc_min, acc_max;
  logic signed [ACC_WIDTH-1:0]  acc_min_next, acc_max_next;
  coord_t                       pos_d1, pos_d2;

  function automatic coord_t sat_coord(input logic signed [DIFF_WIDTH-1:0] v);
    logic [DIFF_WIDTH-COORD_WIDTH:0] top;
    top = v[DIFF_WIDTH-1:COORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[DIFF_WIDTH-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  // floored Q16.16 products, one per corner value and column
  always_comb begin
    logic signed [COEF_WIDTH-1:0] coef;
    logic signed [PROD_WIDTH-1:0] prod_lo, prod_hi;
    for (int c = 0; c < NUM_COLS; c++) begin
      coef    = $signed(row[c*COEF_WIDTH +: COEF_WIDTH]);
      prod_lo = $signed(lo_sum[c]) * coef;
      prod_hi = $signed(hi_sum[c]) * coef;
      term_lo_next[c] = prod_lo[PROD_WIDTH-1:FRAC_BITS];
      term_hi_next[c] = prod_hi[PROD_WIDTH-1:FRAC_BITS];
    end
  end

  // the sum is separable per column, so the corner extremes are sums of column extremes
  always_comb begin
    logic signed [TERM_WIDTH-1:0] tmin, tmax;
    acc_min_next = ACC_WIDTH'(shift);
    acc_max_next = ACC_WIDTH'(shift);
    for (int c = 0; c < NUM_COLS; c++) begin
      if (term_lo[c] < term_hi[c]) begin
        tmin = term_lo[c];
        tmax = term_hi[c];
      end else begin
        tmin = term_hi[c];
        tmax = term_lo[c];
      end
      acc_min_next = acc_min_next + ACC_WIDTH'(tmin);
      acc_max_next = acc_max_next + ACC_WIDTH'(tmax);
    end
  end

  always_ff @(posedge clk) begin
    term_lo <= term_lo_next;
    term_hi <= term_hi_next;
    pos_d1  <= pos;
    acc_min <= acc_min_next;
    acc_max <= acc_max_next;
    pos_d2  <= pos_d1;
  end

  assign lo_res = sat_coord(DIFF_WIDTH'(acc_min) - DIFF_WIDTH'(pos_d2));
  assign hi_res = sat_coord(DIFF_WIDTH'(acc_max) - DIFF_WIDTH'(pos_d2));

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the box affine transform unit: directed table, then random boxes.
module tb;
  import aabbt_pkg::*;

  localparam coord_t CMIN = 32'sh8000_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam logic [COEF_WIDTH-1:0] COEF_MAX     = 20'h7ffff;
  localparam logic [COEF_WIDTH-1:0] COEF_MIN     = 20'h80000;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE     = 20'h10000;
  localparam logic [COEF_WIDTH-1:0] COEF_NEG_ONE = 20'hf0000;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_7 = 3'd7;
  localparam int PIPE_LATENCY    = 4;
  localparam int RAND_PHASES     = 6;
  localparam int BOXES_PER_PHASE = 300;
  localparam int MAX_REPORTS     = 10;

  // element 5 is new_lo_x, element 0 is new_hi_z
  typedef coord_t [5:0] out_fields_t;
  typedef enum {STEP_WRITE, STEP_BOX} step_kind_t;
  typedef struct {
    step_kind_t                 kind;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    logic [CFG_DATA_WIDTH-1:0]  data;
    box_in_t                    req;
    bit                         pinned;
    box_out_t                   want;
  } stim_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  box_in_t                    request = '0;
  logic                       done;
  box_out_t                   result;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  bit       pin_on = 1'b0;
  box_out_t pin_want = '0;

  logic [ROW_WIDTH-1:0] coef_row [3];
  coord_t               shift_reg [3];
  box_out_t             pending_boxes [$];
  stim_row_t            dir_tab [$];
  int                   mismatch_count = 0;
  string field_name [6] = '{"new_hi_z", "new_hi_y", "new_hi_x",
                            "new_lo_z", "new_lo_y", "new_lo_x"};

  aabb_affine_transform_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(CMAX)) return CMAX;
    if (v < longint'(CMIN)) return CMIN;
    return coord_t'(v);
  endfunction

  // Transform all eight corners, take per-axis extremes, remove the position and clamp.
  function automatic box_out_t transform_box(box_in_t b);
    coord_t lo [3];
    coord_t hi [3];
    coord_t ps [3];
    longint pt [3];
    longint mn [3];
    longint mx [3];
    longint acc;
    logic signed [COEF_WIDTH-1:0] cf;
    out_fields_t o;
    lo = '{b.lo_x, b.lo_y, b.lo_z};
    hi = '{b.hi_x, b.hi_y, b.hi_z};
    ps = '{b.pos_x, b.pos_y, b.pos_z};
    for (int k = 0; k < 8; k++) begin
      for (int c = 0; c < 3; c++)
        pt[c] = longint'(k[2-c] ? hi[c] : lo[c]) + longint'(ps[c]);
      for (int a = 0; a < 3; a++) begin
        acc = longint'(shift_reg[a]);
        for (int c = 0; c < 3; c++) begin
          cf = coef_row[a][c*COEF_WIDTH +: COEF_WIDTH];
          // floor each product to Q16.16 before summing
          acc += (pt[c] * longint'(cf)) >>> FRAC_BITS;
        end
        if (k == 0 || acc < mn[a]) mn[a] = acc;
        if (k == 0 || acc > mx[a]) mx[a] = acc;
      end
    end
    for (int a = 0; a < 3; a++) begin
      o[5-a] = clamp_coord(mn[a] - longint'(ps[a]));
      o[2-a] = clamp_coord(mx[a] - longint'(ps[a]));
    end
    return box_out_t'(o);
  endfunction

  function automatic box_in_t mk_box(coord_t lx, coord_t ly, coord_t lz,
                                     coord_t hx, coord_t hy, coord_t hz,
                                     coord_t px, coord_t py, coord_t pz);
    return box_in_t'({lx, ly, lz, hx, hy, hz, px, py, pz});
  endfunction

  function automatic box_out_t mk_out(coord_t lx, coord_t ly, coord_t lz,
                                      coord_t hx, coord_t hy, coord_t hz);
    return box_out_t'({lx, ly, lz, hx, hy, hz});
  endfunction

  function automatic stim_row_t wr_row(logic [CFG_INDEX_WIDTH-1:0] idx,
                                       logic [CFG_DATA_WIDTH-1:0] val);
    stim_row_t r;
    r.kind   = STEP_WRITE;
    r.idx    = idx;
    r.data   = val;
    r.req    = '0;
    r.pinned = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t box_row(box_in_t b, bit pin, box_out_t w);
    stim_row_t r;
    r.kind   = STEP_BOX;
    r.idx    = '0;
    r.data   = '0;
    r.req    = b;
    r.pinned = pin;
    r.want   = w;
    return r;
  endfunction

  // append a row to the directed table
  function automatic void add_step(stim_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 60) return coord_t'(int'($urandom_range(32'h20_0000)) - 32'sh10_0000);
    if (r < 85) return coord_t'($urandom);
    case ($urandom_range(4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [COEF_WIDTH-1:0] rand_coef(int scheme);
    case (scheme)
      0: return COEF_WIDTH'($urandom);
      1: return COEF_WIDTH'(int'($urandom_range(32'h4_0000)) - 32'sh2_0000);
      default: begin
        case ($urandom_range(4))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return '0;
          3:       return COEF_ONE;
          default: return COEF_NEG_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic box_in_t rand_box();
    box_in_t b;
    b = mk_box(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord(), rand_coord());
    // mostly well-ordered boxes, the rest left as drawn
    if ($urandom_range(99) < 80) begin
      if (b.lo_x > b.hi_x) {b.lo_x, b.hi_x} = {b.hi_x, b.lo_x};
      if (b.lo_y > b.hi_y) {b.lo_y, b.hi_y} = {b.hi_y, b.lo_y};
      if (b.lo_z > b.hi_z) {b.lo_z, b.hi_z} = {b.hi_z, b.lo_z};
    end
    return b;
  endfunction

  // Hold start low, wait for every result, then let the pipeline settle.
  task automatic drain_pipe();
    start  <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic cfg_put(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic send_box(box_in_t b, bit pin, box_out_t w, int idle_pct);
    cfg_we <= 1'b0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    start    <= 1'b1;
    request  <= b;
    pin_on   <= pin;
    pin_want <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_fields_t want_f;
    out_fields_t got_f;
    if (rst) begin
      coef_row[0]  = ROW_X_RESET;
      coef_row[1]  = ROW_Y_RESET;
      coef_row[2]  = ROW_Z_RESET;
      shift_reg[0] = '0;
      shift_reg[1] = '0;
      shift_reg[2] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_X, REG_ROW_Y, REG_ROW_Z:
            coef_row[cfg_index[1:0]] = cfg_data;
          REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z:
            shift_reg[2'(cfg_index - REG_SHIFT_X)] = cfg_data[COORD_WIDTH-1:0];
          default: ;  // spare indices: drop the write
        endcase
      end
      if (done) begin
        if (pending_boxes.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) $display("unexpected result %h", result);
          mismatch_count++;
        end else begin
          want_f = out_fields_t'(pending_boxes.pop_front());
          got_f  = out_fields_t'(result);
          for (int i = 0; i < 6; i++) begin
            if (got_f[i] !== want_f[i]) begin
              if (mismatch_count < MAX_REPORTS)
                $display("%s mismatch: expected %h, actual %h",
                         field_name[i], want_f[i], got_f[i]);
              mismatch_count++;
            end
          end
        end
      end
      if (start && !busy)
        pending_boxes.insert(pending_boxes.size(),
                             pin_on ? pin_want : transform_box(request));
    end
  end

  initial begin
    int                        scheme;
    int                        idle_pct;
    bit                        prev_write;
    logic [CFG_DATA_WIDTH-1:0] row;

    // identity after reset: the result is the box with its corners ordered
    add_step(box_row(mk_box(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_out(0, 0, 0, 0, 0, 0)));
    add_step(box_row(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0), 1'b1,
                     mk_out(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX)));
    add_step(box_row(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
                     1'b1, mk_out(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX)));
    add_step(box_row(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN),
                     1'b1, mk_out(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX)));
    add_step(box_row(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, 0),
                     1'b1, mk_out(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX)));
    add_step(box_row(mk_box(32'sh1_0000, -32'sh2_8000, 5, -32'sh1_0000, 32'sh8000, 5,
                            123, -7, 32'sh7fff_0000), 1'b1,
                     mk_out(-32'sh1_0000, -32'sh2_8000, 5, 32'sh1_0000, 32'sh8000, 5)));
    add_step(box_row(mk_box(-1, -1, -1, 1, 1, 1, -1, -1, -1), 1'b1,
                     mk_out(-1, -1, -1, 1, 1, 1)));
    // spare indices must leave the identity untouched
    add_step(wr_row(REG_SPARE_6, '1));
    add_step(wr_row(REG_SPARE_7, '0));
    add_step(box_row(mk_box(1, 2, 3, 4, 5, 6, CMIN, CMIN, CMIN), 1'b1,
                     mk_out(1, 2, 3, 4, 5, 6)));
    // translations with junk above bit 31
    add_step(wr_row(REG_SHIFT_X, {28'hfff_ffff, 32'h0001_0000}));
    add_step(wr_row(REG_SHIFT_Y, {28'hfff_ffff, 32'hffff_0000}));
    add_step(wr_row(REG_SHIFT_Z, {28'hfff_ffff, 32'h0000_0000}));
    add_step(box_row(mk_box(0, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0, 0, 0),
                     1'b1, mk_out(32'sh1_0000, -32'sh1_0000, 0,
                                  32'sh2_0000, 0, 32'sh1_0000)));
    // largest coefficients and translation
    add_step(wr_row(REG_ROW_X, {3{COEF_MAX}}));
    add_step(wr_row(REG_ROW_Y, {3{COEF_MAX}}));
    add_step(wr_row(REG_ROW_Z, {3{COEF_MAX}}));
    add_step(wr_row(REG_SHIFT_X, {28'h0, CMAX}));
    add_step(wr_row(REG_SHIFT_Y, {28'h0, CMAX}));
    add_step(wr_row(REG_SHIFT_Z, {28'h0, CMAX}));
    add_step(box_row(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
                     1'b0, '0));
    add_step(box_row(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN),
                     1'b0, '0));
    add_step(box_row(mk_box(0, 0, 0, 1, 1, 1, 0, 0, 0), 1'b0, '0));
    // most negative coefficients and translation
    add_step(wr_row(REG_ROW_X, {3{COEF_MIN}}));
    add_step(wr_row(REG_ROW_Y, {3{COEF_MIN}}));
    add_step(wr_row(REG_ROW_Z, {3{COEF_MIN}}));
    add_step(wr_row(REG_SHIFT_X, {28'hfff_ffff, CMIN}));
    add_step(wr_row(REG_SHIFT_Y, {28'hfff_ffff, CMIN}));
    add_step(wr_row(REG_SHIFT_Z, {28'hfff_ffff, CMIN}));
    add_step(box_row(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
                     1'b0, '0));
    add_step(box_row(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN),
                     1'b0, '0));
    add_step(box_row(mk_box(0, 0, 0, 1, 1, 1, 0, 0, 0), 1'b0, '0));
    // zero transform: the result is minus the position, saturated
    add_step(wr_row(REG_ROW_X, '0));
    add_step(wr_row(REG_ROW_Y, '0));
    add_step(wr_row(REG_ROW_Z, '0));
    add_step(wr_row(REG_SHIFT_X, '0));
    add_step(wr_row(REG_SHIFT_Y, '0));
    add_step(wr_row(REG_SHIFT_Z, '0));
    add_step(box_row(mk_box(0, 0, 0, 0, 0, 0, CMIN, CMIN, CMIN), 1'b1,
                     mk_out(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX)));
    add_step(box_row(mk_box(5, 5, 5, 7, 7, 7, CMAX, CMAX, CMAX), 1'b1,
                     mk_out(-CMAX, -CMAX, -CMAX, -CMAX, -CMAX, -CMAX)));

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    prev_write = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STEP_WRITE) begin
        if (!prev_write) drain_pipe();
        cfg_put(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_box(dir_tab[i].req, dir_tab[i].pinned, dir_tab[i].want, 25);
      end
      prev_write = (dir_tab[i].kind == STEP_WRITE);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_pipe();
      // full range, within +/-2.0, extremes, identity
      scheme = ph % 4;
      for (int a = 0; a < 3; a++) begin
        if (scheme == 3) row = ROW_X_RESET << (a * COEF_WIDTH);
        else row = {rand_coef(scheme), rand_coef(scheme), rand_coef(scheme)};
        cfg_put(CFG_INDEX_WIDTH'(REG_ROW_X + a), row);
      end
      for (int a = 0; a < 3; a++)
        cfg_put(CFG_INDEX_WIDTH'(REG_SHIFT_X + a), {28'($urandom), rand_coord()});
      idle_pct = (ph == RAND_PHASES - 1) ? 0 : 10 * $urandom_range(5);
      for (int n = 0; n < BOXES_PER_PHASE; n++)
        send_box(rand_box(), 1'b0, '0, idle_pct);
    end

    drain_pipe();
    if (mismatch_count == 0 && pending_boxes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: aabb_affine_transform_unit.f
rtl/core/aabbt_pkg.sv
rtl/core/aabbt_axis.sv
rtl/core/aabb_affine_transform_unit.sv
sim/tb.sv
